// ===== design/pcx_pkg.sv =====
// Shared types and constants of the PCX run-length pixel decoder.
package pcx_pkg;

	// Input command codes
	localparam logic [1:0] CMD_PALETTE = 2'd0;
	localparam logic [1:0] CMD_FILE    = 2'd1;
	localparam logic [1:0] CMD_RESTART = 2'd2;

	// Palette geometry
	localparam int PAL_ENTRIES = 256;

	// Header layout
	localparam int         HDR_LEN         = 128;
	localparam int         OFF_W           = 7;
	localparam logic [6:0] HDR_OFF_ID      = 7'd0;
	localparam logic [6:0] HDR_OFF_BPP     = 7'd3;
	localparam logic [6:0] HDR_OFF_WIN     = 7'd4;
	localparam logic [6:0] HDR_OFF_WIN_END = 7'd11;
	localparam logic [7:0] HDR_ID          = 8'd10;
	localparam logic [7:0] HDR_BPP         = 8'd8;

	// Run code marker in the top two bits of a data byte
	localparam logic [1:0] RUN_MARK = 2'b11;

	// Result kinds
	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// Controller sequencing state
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_ERROR
	} state_t;

	// Decoding phase of the current image
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_DONE
	} phase_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic pal_write;
		logic restart;
		logic hdr_advance;
		logic run_load;
		logic pix_start;
		logic pix_emit;
		logic err_emit;
	} ctl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic hdr_error;
		logic hdr_empty;
		logic hdr_last;
		logic run_nz;
		logic byte_is_run;
		logic emit_last;
		logic end_image;
	} dp_status_t;

endpackage

// ===== design/pcx_ctrl.sv =====
// Controller state machine of the PCX decoder: sequences transactions and results.
module pcx_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	output logic                out_valid,
	input  logic                out_ready,
	input  pcx_pkg::dp_status_t st,
	output pcx_pkg::ctl_cmd_t   ctl
);
	import pcx_pkg::*;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   out_valid_q;
	logic   accept;
	logic   slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// Next state and next phase
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_RESTART) begin
						phase_d = PH_HEADER;
					end else if (cmd == CMD_FILE) begin
						unique case (phase_q)
							PH_HEADER: begin
								if (st.hdr_error) begin
									state_d = ST_ERROR;
									phase_d = PH_DONE;
								end else if (st.hdr_empty) begin
									phase_d = PH_DONE;
								end else if (st.hdr_last) begin
									phase_d = PH_DATA;
								end
							end
							PH_DATA: begin
								if (st.run_nz || !st.byte_is_run) begin
									state_d = ST_EMIT;
								end
							end
							PH_DONE: ;
							default: ;
						endcase
					end
				end
			end
			ST_EMIT: begin
				if (slot_free && st.emit_last) begin
					state_d = ST_IDLE;
					if (st.end_image) begin
						phase_d = PH_DONE;
					end
				end
			end
			ST_ERROR: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.pal_write = (cmd == CMD_PALETTE);
					ctl.restart   = (cmd == CMD_RESTART);
					if (cmd == CMD_FILE) begin
						if (phase_q == PH_HEADER) begin
							ctl.hdr_advance = !st.hdr_error;
						end else if (phase_q == PH_DATA) begin
							ctl.pix_start = st.run_nz || !st.byte_is_run;
							ctl.run_load  = !st.run_nz && st.byte_is_run;
						end
					end
				end
			end
			ST_EMIT:  ctl.pix_emit = slot_free;
			ST_ERROR: ctl.err_emit = slot_free;
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_HEADER;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	// Hold the output transaction until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.pix_emit || ctl.err_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== design/pcx_dpath.sv =====
// Datapath of the PCX decoder: palette memory, header fields, position and result registers.
module pcx_dpath #(
	parameter int MAX_DIM = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          data_byte,
	input  logic [11:0]         origin_x,
	input  logic [11:0]         origin_y,
	input  pcx_pkg::ctl_cmd_t   ctl,
	output pcx_pkg::dp_status_t st,
	output logic                kind,
	output logic [12:0]         pix_x,
	output logic [12:0]         pix_y,
	output logic [7:0]          color,
	output logic                last
);
	import pcx_pkg::*;

	localparam int COL_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam logic signed [17:0] DIM_S = 18'(MAX_DIM);
	localparam logic [1:0] COMP_R = 2'd0;
	localparam logic [1:0] COMP_G = 2'd1;
	localparam logic [1:0] COMP_B = 2'd2;

	// Palette storage and fill position
	logic [7:0]       pal_mem [PAL_ENTRIES];
	logic [7:0]       pal_idx_q;
	logic [1:0]       pal_comp_q;
	logic             pal_full_q;
	logic [7:0]       pal_acc_q;
	logic [7:0]       pal_entry;
	logic             pal_we;
	logic [7:0]       color_q;

	// Header fields
	logic [OFF_W-1:0] off_q;
	logic [7:0]       win_q [8];
	logic [15:0]      xmin, ymin, xmax, ymax;
	logic signed [17:0] w_s, h_s;
	logic             width_bad;
	logic             in_window;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// Position and run state
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic [5:0]       run_q;
	logic [5:0]       cnt_q;
	logic             end_col;
	logic             end_row;

	// Result registers
	logic             kind_q;
	logic [12:0]      x_q;
	logic [12:0]      y_q;
	logic [7:0]       color_out_q;
	logic             last_q;

	assign pal_we = ctl.pal_write && !pal_full_q;

	// Merge the incoming component into the entry being built
	always_comb begin
		unique case (pal_comp_q)
			COMP_R:  pal_entry = {data_byte[7:5], 5'b00000};
			COMP_G:  pal_entry = {pal_acc_q[7:5], data_byte[7:5], pal_acc_q[1:0]};
			COMP_B:  pal_entry = {pal_acc_q[7:2], data_byte[7:6]};
			default: pal_entry = pal_acc_q;
		endcase
	end

	// Advance the palette fill position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_idx_q  <= '0;
			pal_comp_q <= COMP_R;
			pal_full_q <= 1'b0;
		end else if (ctl.restart) begin
			pal_idx_q  <= '0;
			pal_comp_q <= COMP_R;
			pal_full_q <= 1'b0;
		end else if (pal_we) begin
			if (pal_comp_q == COMP_B) begin
				pal_comp_q <= COMP_R;
				pal_idx_q  <= pal_idx_q + 8'd1;
				if (pal_idx_q == 8'(PAL_ENTRIES - 1)) begin
					pal_full_q <= 1'b1;
				end
			end else begin
				pal_comp_q <= pal_comp_q + 2'd1;
			end
		end
	end

	// Write the partial entry each component; read the pixel color on a data byte
	always_ff @(posedge clk) begin
		if (pal_we) begin
			pal_mem[pal_idx_q] <= pal_entry;
			pal_acc_q          <= pal_entry;
		end
		if (ctl.pix_start) begin
			color_q <= pal_mem[data_byte];
		end
	end

	// Window words; the last byte of ymax is the one arriving now
	assign xmin = {win_q[1], win_q[0]};
	assign ymin = {win_q[3], win_q[2]};
	assign xmax = {win_q[5], win_q[4]};
	assign ymax = {data_byte, win_q[6]};
	assign w_s  = $signed({2'b00, xmax}) - $signed({2'b00, xmin}) + 18'sd1;
	assign h_s  = $signed({2'b00, ymax}) - $signed({2'b00, ymin}) + 18'sd1;
	assign width_bad = (w_s < 18'sd1) || (w_s > DIM_S);
	assign in_window = (off_q >= HDR_OFF_WIN) && (off_q <= HDR_OFF_WIN_END);

	// Header offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (ctl.restart) begin
			off_q <= '0;
		end else if (ctl.hdr_advance) begin
			off_q <= off_q + 7'd1;
		end
	end

	// Capture window bytes and image size
	always_ff @(posedge clk) begin
		if (ctl.hdr_advance && in_window) begin
			win_q[3'(off_q - HDR_OFF_WIN)] <= data_byte;
		end
		if (ctl.hdr_advance && off_q == HDR_OFF_WIN_END) begin
			width_q  <= w_s[DIM_W-1:0];
			height_q <= (h_s > DIM_S) ? DIM_W'(MAX_DIM) : h_s[DIM_W-1:0];
		end
	end

	// Position of the next pixel
	assign end_col = (DIM_W'(col_q) + DIM_W'(1)) >= width_q;
	assign end_row = (DIM_W'(row_q) + DIM_W'(1)) >= height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			run_q <= '0;
			cnt_q <= '0;
		end else if (ctl.restart) begin
			col_q <= '0;
			row_q <= '0;
			run_q <= '0;
			cnt_q <= '0;
		end else begin
			if (ctl.run_load) begin
				run_q <= data_byte[5:0];
			end
			if (ctl.pix_start) begin
				run_q <= '0;
				cnt_q <= (run_q != 6'd0) ? run_q : 6'd1;
			end
			if (ctl.pix_emit) begin
				cnt_q <= cnt_q - 6'd1;
				if (end_col) begin
					col_q <= '0;
					row_q <= row_q + COL_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (ctl.pix_emit) begin
			kind_q      <= KIND_PIXEL;
			x_q         <= {1'b0, origin_x} + 13'(col_q);
			y_q         <= {1'b0, origin_y} + 13'(row_q);
			color_out_q <= color_q;
			last_q      <= st.emit_last;
		end else if (ctl.err_emit) begin
			kind_q      <= KIND_ERROR;
			x_q         <= '0;
			y_q         <= '0;
			color_out_q <= '0;
			last_q      <= 1'b1;
		end
	end

	// Status toward the controller
	assign st.hdr_error = ((off_q == HDR_OFF_ID) && (data_byte != HDR_ID))
		|| ((off_q == HDR_OFF_BPP) && (data_byte != HDR_BPP))
		|| ((off_q == HDR_OFF_WIN_END) && width_bad);
	assign st.hdr_empty   = (off_q == HDR_OFF_WIN_END) && (h_s < 18'sd1);
	assign st.hdr_last    = (off_q == OFF_W'(HDR_LEN - 1));
	assign st.run_nz      = (run_q != 6'd0);
	assign st.byte_is_run = (data_byte[7:6] == RUN_MARK);
	assign st.end_image   = end_col && end_row;
	assign st.emit_last   = (cnt_q == 6'd1) || (end_col && end_row);

	assign kind  = kind_q;
	assign pix_x = x_q;
	assign pix_y = y_q;
	assign color = color_out_q;
	assign last  = last_q;

endmodule

// ===== design/pcx_rle_pixel_decoder.sv =====
// The first pixel of a data byte is offered once the emit state has loaded the result
// register. Palette, good header and run-length bytes keep the controller idle; literal
// or run color bytes hold input off; palette colors leave one per cycle unless stalled.
// A full output register lets the next input transaction in while its result waits.
// Reset (arst_n low) clears origin registers, fill count, header offset, position and
// run state; palette memory is not cleared and holds nothing until written.
module pcx_rle_pixel_decoder #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [12:0] pix_x,
	output logic [12:0] pix_y,
	output logic [7:0]  color,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcx_pkg::*;

	localparam logic REG_ORIGIN_X = 1'b0;
	localparam logic REG_ORIGIN_Y = 1'b1;

	logic [11:0] origin_x_q;
	logic [11:0] origin_y_q;
	logic        cfg_write;
	ctl_cmd_t    ctl;
	dp_status_t  st;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
		end else if (cfg_write) begin
			if (paddr[2] == REG_ORIGIN_X) begin
				origin_x_q <= pwdata[11:0];
			end else begin
				origin_y_q <= pwdata[11:0];
			end
		end
	end

	// Register read-back
	always_comb begin
		unique case (paddr[2])
			REG_ORIGIN_X: prdata = {20'd0, origin_x_q};
			REG_ORIGIN_Y: prdata = {20'd0, origin_y_q};
			default:      prdata = '0;
		endcase
	end

	pcx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.ctl       (ctl)
	);

	pcx_dpath #(
		.MAX_DIM (MAX_DIM)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.origin_x  (origin_x_q),
		.origin_y  (origin_y_q),
		.ctl       (ctl),
		.st        (st),
		.kind      (kind),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.color     (color),
		.last      (last)
	);

endmodule

// ===== design/pcx_checker.sv =====
// Port-level checker of the PCX decoder and its bind to the top level.
module pcx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [12:0] pix_x,
	input logic [12:0] pix_y,
	input logic [7:0]  color,
	input logic        last
);
	import pcx_pkg::*;

	// Hold a stalled result transaction unchanged
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pix_x)
			&& $stable(pix_y) && $stable(color) && $stable(last))
		else $error("stalled result changed or dropped");

	// Palette and restart transactions never stall the input side
	a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == CMD_PALETTE || cmd == CMD_RESTART) |=> in_ready)
		else $error("input stalled after a palette or restart transaction");

	// While a run is still being placed, take no new input
	a_run_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input accepted before the run finished");

	// An error result closes its input's results
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> last && !in_valid || last)
		else $error("error result without last");

endmodule

bind pcx_rle_pixel_decoder pcx_checker u_pcx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.cmd       (cmd),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.pix_x     (pix_x),
	.pix_y     (pix_y),
	.color     (color),
	.last      (last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the PCX run-length pixel decoder: palette load, headers, pixel runs.
module tb;
	import pcx_pkg::*;

	localparam int MAX_DIM         = 4096;
	localparam int PAL_BYTES       = 3 * PAL_ENTRIES;
	localparam int PAL_USED        = 3;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int STALL_LIMIT     = 4000;
	localparam int ITEM_TARGET     = 190;
	localparam int DRAIN_CYCLES    = 40;

	localparam logic [1:0] CMD_UNUSED    = 2'd3;
	localparam logic [2:0] ADDR_ORIGIN_X = 3'd0;
	localparam logic [2:0] ADDR_ORIGIN_Y = 3'd4;

	typedef struct packed {
		logic        kind;
		logic [12:0] x;
		logic [12:0] y;
		logic [7:0]  rgb;
		logic        last;
	} pixel_t;

	// Tracks decoder state and the pixels it still owes
	class pixel_tracker;
		logic [7:0]  pal [PAL_ENTRIES];
		int          pal_fill;
		int          hdr_off;
		logic [63:0] win;
		int          col_q;
		int          row_q;
		int          run_cnt;
		phase_t      ph;
		logic [11:0] org_x;
		logic [11:0] org_y;
		pixel_t      due_pixels[$];
		int          n_err;
		int          n_seen;

		function new();
			foreach (pal[i]) pal[i] = '0;
			org_x = '0;
			org_y = '0;
			n_err = 0;
			n_seen = 0;
			clear_image();
		endfunction

		function void clear_image();
			pal_fill = 0;
			hdr_off = 0;
			win = '0;
			col_q = 0;
			row_q = 0;
			run_cnt = 0;
			ph = PH_HEADER;
		endfunction

		function int win_word(int k);
			return {16'd0, win[k * 16 +: 16]};
		endfunction

		function int img_width();
			return win_word(2) - win_word(0) + 1;
		endfunction

		// Clamp tall windows to the largest supported height
		function int img_height();
			int h;
			h = win_word(3) - win_word(1) + 1;
			return (h > MAX_DIM) ? MAX_DIM : h;
		endfunction

		function void put_error();
			due_pixels.push_back({KIND_ERROR, 13'd0, 13'd0, 8'd0, 1'b1});
			ph = PH_DONE;
		endfunction

		// Place one pixel, then advance column and row
		function void place_pixel(logic [7:0] c);
			due_pixels.push_back({KIND_PIXEL, 13'(org_x + col_q), 13'(org_y + row_q), c, 1'b0});
			col_q++;
			if (col_q >= img_width()) begin
				col_q = 0;
				row_q++;
				if (row_q >= img_height())
					ph = PH_DONE;
			end
		endfunction

		function void decode_file_byte(logic [7:0] b);
			int w;
			int cnt;
			if (ph == PH_HEADER) begin
				if ((hdr_off == HDR_OFF_ID && b != HDR_ID) ||
						(hdr_off == HDR_OFF_BPP && b != HDR_BPP)) begin
					put_error();
					return;
				end
				if (hdr_off >= HDR_OFF_WIN && hdr_off <= HDR_OFF_WIN_END)
					win[(hdr_off - HDR_OFF_WIN) * 8 +: 8] = b;
				if (hdr_off == HDR_OFF_WIN_END) begin
					w = img_width();
					if (w < 1 || w > MAX_DIM) begin
						put_error();
						return;
					end
					if (img_height() < 1)
						ph = PH_DONE;
				end
				hdr_off++;
				if (hdr_off >= HDR_LEN && ph == PH_HEADER)
					ph = PH_DATA;
			end else if (ph == PH_DATA) begin
				if (run_cnt != 0) begin
					cnt = run_cnt;
					run_cnt = 0;
					for (int i = 0; i < cnt && ph == PH_DATA; i++)
						place_pixel(pal[b]);
				end else if (b[7:6] == RUN_MARK) begin
					run_cnt = b[5:0];
				end else begin
					place_pixel(pal[b]);
				end
			end
		endfunction

		// Note one accepted input transaction and queue what it produces
		function void take_byte(logic [1:0] c, logic [7:0] b);
			int n_was;
			int idx;
			pixel_t p;
			n_was = due_pixels.size();
			if (c == CMD_PALETTE) begin
				if (pal_fill < PAL_BYTES) begin
					idx = pal_fill / 3;
					case (pal_fill % 3)
						0: pal[idx] = {b[7:5], 5'd0};
						1: pal[idx][4:2] = b[7:5];
						default: pal[idx][1:0] = b[7:6];
					endcase
					pal_fill++;
				end
			end else if (c == CMD_RESTART) begin
				clear_image();
			end else if (c == CMD_FILE) begin
				decode_file_byte(b);
			end
			// flag the final result of this transaction
			if (due_pixels.size() > n_was) begin
				p = due_pixels.pop_back();
				p.last = 1'b1;
				due_pixels.push_back(p);
			end
		endfunction

		task report(string msg);
			n_err++;
			if (n_err <= 100)
				$display("MISMATCH %s", msg);
		endtask

		task cmp_field(string name, int got, int want);
			if (got != want)
				report($sformatf("result %0d: %s is %0d, want %0d", n_seen, name, got, want));
		endtask

		// Check one accepted output transaction against the oldest pixel owed
		task match_pixel(pixel_t got);
			pixel_t want;
			n_seen++;
			if (due_pixels.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", n_seen));
				return;
			end
			want = due_pixels.pop_front();
			cmp_field("kind", got.kind, want.kind);
			cmp_field("pix_x", got.x, want.x);
			cmp_field("pix_y", got.y, want.y);
			cmp_field("color", got.rgb, want.rgb);
			cmp_field("last", got.last, want.last);
		endtask
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd       = CMD_PALETTE;
	logic [7:0]  data_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        kind;
	logic [12:0] pix_x;
	logic [12:0] pix_y;
	logic [7:0]  color;
	logic        last;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	pixel_tracker sb;
	int burst_left   = 0;
	int idle_cycles  = 0;
	int n_items      = 0;
	bit hold_off_req = 1'b0;

	pcx_rle_pixel_decoder #(.MAX_DIM(MAX_DIM)) uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check every accepted output transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_pixel(pixel_t'({kind, pix_x, pix_y, color, last}));
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Stall the output in patterns; hold off for a long stretch on request
	initial begin : sink
		int mode;
		int span;
		wait (arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 60);
			for (int k = 0; k < span && !hold_off_req; k++) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= ($urandom_range(0, 3) != 0);
					2: out_ready <= (k % 5 != 4);
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
				@(posedge clk);
			end
		end
	end

	// Offer one input transaction in bursts with random gaps, wait for acceptance
	task automatic push_byte(input logic [1:0] c, input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= c;
		data_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.take_byte(c, b);
		n_items++;
	endtask

	// Drop valid and wait until all owed pixels are out and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.due_pixels.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// Write one register, then read it back
	task automatic cfg_write(input logic [2:0] addr, input logic [11:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {20'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {20'd0, v})
			sb.report($sformatf("register at %0d reads %0h, want %0h", addr, prdata, v));
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_ORIGIN_X)
			sb.org_x = v;
		else
			sb.org_y = v;
	endtask

	task automatic set_origin(input logic [11:0] ox, input logic [11:0] oy);
		settle();
		cfg_write(ADDR_ORIGIN_X, ox);
		cfg_write(ADDR_ORIGIN_Y, oy);
	endtask

	// Restart, then send the first header bytes with the given identity and window
	task automatic send_header(input logic [7:0] id, input logic [7:0] bpp,
			input logic [15:0] x0, input logic [15:0] y0,
			input logic [15:0] x1, input logic [15:0] y1, input int n_bytes);
		logic [63:0] win;
		logic [7:0]  b;
		win = {y1, x1, y0, x0};
		push_byte(CMD_RESTART, 8'($urandom));
		for (int off = 0; off < n_bytes; off++) begin
			b = 8'($urandom);
			if (off == HDR_OFF_ID)
				b = id;
			else if (off == HDR_OFF_BPP)
				b = bpp;
			else if (off >= HDR_OFF_WIN && off <= HDR_OFF_WIN_END)
				b = win[(off - HDR_OFF_WIN) * 8 +: 8];
			push_byte(CMD_FILE, b);
		end
	endtask

	task automatic put_run(input int n, input logic [7:0] c);
		push_byte(CMD_FILE, {RUN_MARK, 6'(n)});
		push_byte(CMD_FILE, c);
	endtask

	// Mostly literals and runs on loaded colors, with palette writes, restarts and unused commands
	task automatic random_data_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			push_byte(CMD_FILE, 8'($urandom_range(0, PAL_USED - 1)));
		else if (r < 80)
			put_run(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6),
				8'($urandom_range(0, PAL_USED - 1)));
		else if (r < 88)
			push_byte(CMD_PALETTE, 8'($urandom));
		else if (r < 96)
			push_byte(CMD_UNUSED, 8'($urandom));
		else
			push_byte(CMD_RESTART, 8'($urandom));
	endtask

	initial begin : stimulus
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_origin(12'hFF9, 12'hFFC);

		// load the first palette entries; pixels only ever use these
		repeat (3 * PAL_USED) push_byte(CMD_PALETTE, 8'($urandom));

		// rejected headers: identity, bit depth, oversized width
		push_byte(CMD_FILE, 8'd0);
		push_byte(CMD_FILE, 8'h11);
		send_header(HDR_ID, 8'd24, 16'd0, 16'd0, 16'd3, 16'd1, 4);
		send_header(HDR_ID, HDR_BPP, 16'd0, 16'd0, 16'd4096, 16'd1, 12);
		// empty height ends the image quietly
		send_header(HDR_ID, HDR_BPP, 16'd0, 16'd5, 16'd2, 16'd4, 12);
		push_byte(CMD_FILE, 8'h01);

		// six by ten image: literals, a zero run, a short run, noise
		send_header(HDR_ID, HDR_BPP, 16'd100, 16'd200, 16'd105, 16'd209, HDR_LEN);
		push_byte(CMD_FILE, 8'h00);
		push_byte(CMD_FILE, {RUN_MARK, 6'd0});
		push_byte(CMD_FILE, 8'h02);
		put_run(3, 8'h01);
		push_byte(CMD_UNUSED, 8'hC3);
		push_byte(CMD_PALETTE, 8'hE0);

		// long run while the sink holds off and input keeps coming
		hold_off_req = 1'b1;
		put_run(40, 8'h02);
		push_byte(CMD_FILE, 8'h01);
		push_byte(CMD_FILE, 8'h00);

		// move the origin, then random data up to the item budget
		set_origin(12'h001, 12'hFFF);
		while (n_items < ITEM_TARGET - 3)
			random_data_item();

		// overrun the last row, then a byte after the end
		put_run(63, 8'h00);
		push_byte(CMD_FILE, 8'h33);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_err == 0 && sb.due_pixels.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
